[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define BINT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define BINT_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  `BINT_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

[src/bint_pkg.sv]
// ----------------------------------------------------------------------------
// bint_pkg
// Constants and codes shared by the bilinear interpolator.
// ----------------------------------------------------------------------------
package bint_pkg;

  // Default breakpoint table depths.
  localparam int unsigned MAX_X_POINTS_DEF = 16;
  localparam int unsigned MAX_Y_POINTS_DEF = 16;

  // Datapath widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned DEN_W  = 2 * MUL_W;
  // Four corner terms of up to 96 bits each, plus sign.
  localparam int unsigned ACC_W  = 100;

  // Word modes.
  localparam logic [1:0] MODE_LOAD_X = 2'd0;
  localparam logic [1:0] MODE_LOAD_Y = 2'd1;
  localparam logic [1:0] MODE_LOAD_V = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EXTRA = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Register indexes (paddr bit 2).
  localparam logic REG_X_POINTS = 1'b0;
  localparam logic REG_Y_POINTS = 1'b1;

  // Configuration register width and reset value.
  localparam int unsigned CNT_REG_W = 5;
  localparam logic [CNT_REG_W-1:0] CNT_REG_RST = 5'd16;

endpackage

[src/bint_div.sv]
// ----------------------------------------------------------------------------
// bint_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bint_div #(
  parameter int unsigned DVD_W = bint_pkg::ACC_W,
  parameter int unsigned DVS_W = bint_pkg::DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             running_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // Shift the next dividend bit into the remainder and try the subtract.
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        running_q <= 1'b1;
        cnt_q     <= CW'(DVD_W);
      end else if (running_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          running_q <= 1'b0;
          done_q    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (running_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/bilinear_interp_nonuniform_grid.sv]
// ----------------------------------------------------------------------------
// bilinear_interp_nonuniform_grid
// Bilinear interpolation over a rectilinear grid with non-uniform breakpoints.
// Operation: a load word completes in the accepting cycle. A query runs two
//   bisection searches through the breakpoint memories (S_SRCH and S_CMP per
//   step), forms the cell area and corner products through the shared 32x32
//   multiplier, then divides in the one-bit-per-cycle divider.
// Throughput: one query at a time; a zero-area cell finishes after the area check.
// Reset: control state and output valid are cleared, point counts set to 16; the
//   breakpoint and value memories keep no reset and must be loaded first.
// ----------------------------------------------------------------------------
module bilinear_interp_nonuniform_grid #(
  parameter int unsigned MAX_X_POINTS = bint_pkg::MAX_X_POINTS_DEF,
  parameter int unsigned MAX_Y_POINTS = bint_pkg::MAX_Y_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input word channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         load_index_i,
  input  logic signed [31:0] load_data_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_y_i,
  // Result word channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] interp_value_o,
  output logic [1:0]         status_o,
  // Configuration port.
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  `include "assert_macros.svh"

  localparam int unsigned XW   = $clog2(MAX_X_POINTS);
  localparam int unsigned YW   = $clog2(MAX_Y_POINTS);
  localparam int unsigned MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
  localparam int unsigned IW   = $clog2(MAXP);
  localparam int unsigned NW   = $clog2(MAXP + 1);
  localparam int unsigned TD   = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int unsigned TW   = $clog2(TD);
  localparam int unsigned AW   = bint_pkg::ACC_W;
  localparam int unsigned MW   = bint_pkg::MUL_W;
  localparam int unsigned DW   = bint_pkg::DEN_W;
  localparam int unsigned RW   = bint_pkg::CNT_REG_W;

  // The query sequencer: search x, search y, cell area, corner products, divide.
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_CMP, S_E0, S_E1, S_E2, S_E3, S_E4,
    S_ZCHK, S_DEN, S_CW, S_CL, S_CH, S_CA, S_DST, S_DIV
  } state_e;

  // Result staging sits in S_DIV until the divider reports done, then in
  // the output register; a separate finish state is folded into S_DIV/S_IDLE
  // via fin_q.

  state_e state_q;
  logic   fin_q;

  // Configuration registers.
  logic [RW-1:0] x_points_used_q;
  logic [RW-1:0] y_points_used_q;
  logic          cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_points_used_q <= bint_pkg::CNT_REG_RST;
      y_points_used_q <= bint_pkg::CNT_REG_RST;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        bint_pkg::REG_X_POINTS: x_points_used_q <= pwdata_i[RW-1:0];
        bint_pkg::REG_Y_POINTS: y_points_used_q <= pwdata_i[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      bint_pkg::REG_X_POINTS: prdata_o = 32'(x_points_used_q);
      bint_pkg::REG_Y_POINTS: prdata_o = 32'(y_points_used_q);
      default:                prdata_o = '0;
    endcase
  end

  // Point counts below two act as two, above the table depth as the depth.
  logic [NW-1:0] nx_c;
  logic [NW-1:0] ny_c;

  always_comb begin
    if (x_points_used_q < RW'(2)) begin
      nx_c = NW'(2);
    end else if (32'(x_points_used_q) > MAX_X_POINTS) begin
      nx_c = NW'(MAX_X_POINTS);
    end else begin
      nx_c = NW'(x_points_used_q);
    end
    if (y_points_used_q < RW'(2)) begin
      ny_c = NW'(2);
    end else if (32'(y_points_used_q) > MAX_Y_POINTS) begin
      ny_c = NW'(MAX_Y_POINTS);
    end else begin
      ny_c = NW'(y_points_used_q);
    end
  end

  // Input handshake. Loads complete in the accepting cycle.
  logic in_acc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Datapath registers.
  logic               axis_q;
  logic [IW-1:0]      lo_q;
  logic [IW-1:0]      hi_q;
  logic [IW-1:0]      mid_q;
  logic [IW-1:0]      i_q;
  logic [NW-1:0]      nx_q;
  logic [NW-1:0]      ny_q;
  logic signed [31:0] qx_q;
  logic signed [31:0] qy_q;
  logic signed [31:0] x1_q;
  logic signed [31:0] x2_q;
  logic signed [31:0] y1_q;
  logic signed [31:0] y2_q;
  logic               outside_q;
  logic               zero_q;
  logic [TW-1:0]      base_q;
  logic [1:0]         c_q;
  logic [MW-1:0]      vmag_q;
  logic               tneg_q;
  logic [DW-1:0]      p1_q;
  logic [DW-1:0]      den_q;
  logic               dneg_q;
  logic signed [AW-1:0] acc_q;
  logic               numneg_q;

  // Result register.
  logic               out_valid_q;
  logic signed [31:0] interp_q;
  logic [1:0]         status_q;

  // Breakpoint and value memories with registered reads.
  logic [31:0] x_mem [MAX_X_POINTS];
  logic [31:0] y_mem [MAX_Y_POINTS];
  logic [31:0] v_mem [TD];
  logic signed [31:0] x_rd_q;
  logic signed [31:0] y_rd_q;
  logic signed [31:0] v_rd_q;
  logic [IW-1:0]      bp_addr;
  logic [TW-1:0]      v_addr;

  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == bint_pkg::MODE_LOAD_X) && (32'(load_index_i) < MAX_X_POINTS)) begin
      x_mem[XW'(load_index_i)] <= load_data_i;
    end
    x_rd_q <= x_mem[XW'(bp_addr)];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == bint_pkg::MODE_LOAD_Y) && (32'(load_index_i) < MAX_Y_POINTS)) begin
      y_mem[YW'(load_index_i)] <= load_data_i;
    end
    y_rd_q <= y_mem[YW'(bp_addr)];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == bint_pkg::MODE_LOAD_V) && (32'(load_index_i) < TD)) begin
      v_mem[TW'(load_index_i)] <= load_data_i;
    end
    v_rd_q <= v_mem[v_addr];
  end

  // Search helpers. The active axis selects the coordinate and read data.
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic [NW-1:0]      n_cur;
  logic [IW-1:0]      n_last;
  logic signed [31:0] q_cur;
  logic signed [31:0] bp_rd;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign n_cur   = axis_q ? ny_q : nx_q;
  assign n_last  = IW'(n_cur - 1'b1);
  assign q_cur   = axis_q ? qy_q : qx_q;
  assign bp_rd   = axis_q ? y_rd_q : x_rd_q;

  always_comb begin
    unique case (state_q)
      S_E0:    bp_addr = '0;
      S_E1:    bp_addr = n_last;
      S_E2:    bp_addr = lo_q;
      S_E3:    bp_addr = lo_q + 1'b1;
      default: bp_addr = mid;
    endcase
  end

  // Corner c reads value (i + c[0]) * ny + (j + c[1]); the next corner's read
  // is issued while the current one is accumulated.
  logic [1:0] c_rd;

  assign c_rd   = (state_q == S_CA) ? c_q + 1'b1 : c_q;
  assign v_addr = base_q + (c_rd[0] ? TW'(ny_q) : TW'(0)) + TW'(lo_q) + TW'(c_rd[1]);

  // Cell widths and corner weights, 33-bit signed differences.
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] wx;
  logic signed [32:0] wy;

  assign dx = {x2_q[31], x2_q} - {x1_q[31], x1_q};
  assign dy = {y2_q[31], y2_q} - {y1_q[31], y1_q};
  assign wx = c_q[0] ? ({qx_q[31], qx_q} - {x1_q[31], x1_q})
                     : ({x2_q[31], x2_q} - {qx_q[31], qx_q});
  assign wy = c_q[1] ? ({qy_q[31], qy_q} - {y1_q[31], y1_q})
                     : ({y2_q[31], y2_q} - {qy_q[31], qy_q});

  function automatic logic [MW-1:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[MW-1:0] : v[MW-1:0];
  endfunction

  function automatic logic [MW-1:0] mag32(input logic signed [31:0] v);
    logic [31:0] n;
    n = -v;
    return v[31] ? n : v;
  endfunction

  // Shared 32x32 multiplier with a registered product. It forms the cell
  // area, each corner's weight product and the two halves of weight * value.
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [DW-1:0] mul_q;

  always_comb begin
    unique case (state_q)
      S_ZCHK: begin
        mul_a = mag33(dx);
        mul_b = mag33(dy);
      end
      S_CW: begin
        mul_a = mag33(wx);
        mul_b = mag33(wy);
      end
      S_CL: begin
        mul_a = mul_q[MW-1:0];
        mul_b = vmag_q;
      end
      S_CH: begin
        mul_a = p1_q[DW-1:MW];
        mul_b = vmag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Corner term halves, sign-applied into the accumulator.
  logic [AW-1:0] term;

  assign term = (state_q == S_CA) ? {(AW - DW - MW)'(0), mul_q, MW'(0)}
                                  : {(AW - DW)'(0), mul_q};

  // Divider for |sum| / |cell area|.
  logic          div_start;
  logic          div_done;
  logic [AW-1:0] div_quo;
  logic [AW-1:0] num_mag;

  assign div_start = (state_q == S_DST);
  assign num_mag   = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);

  bint_div #(
    .DVD_W (AW),
    .DVS_W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Final rounding toward zero is the truncating divide; the sign goes back
  // on afterwards and the magnitude is clamped to the signed 32-bit range.
  logic               qneg;
  logic               sat;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;
  logic [31:0]        quo_neg;

  assign qneg    = numneg_q ^ dneg_q;
  assign sat     = qneg ? (div_quo > AW'(33'h0_8000_0000)) : (div_quo > AW'(33'h0_7FFF_FFFF));
  assign quo_neg = -div_quo[31:0];

  always_comb begin
    if (zero_q) begin
      res_value  = '0;
      res_status = bint_pkg::ST_ZERO;
    end else if (sat) begin
      res_value  = qneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res_status = bint_pkg::ST_SAT;
    end else begin
      res_value  = qneg ? quo_neg : div_quo[31:0];
      res_status = outside_q ? bint_pkg::ST_EXTRA : bint_pkg::ST_OK;
    end
  end

  // The result is ready once the divider is done, or right after the cell
  // check for a zero-area cell; it then waits for a free output register.
  logic res_ready;
  logic out_free;
  logic res_load;

  assign res_ready = fin_q || ((state_q == S_DIV) && div_done);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign res_load  = (state_q == S_DIV) && res_ready && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (mode_i == bint_pkg::MODE_QUERY)) begin
            qx_q      <= query_x_i;
            qy_q      <= query_y_i;
            nx_q      <= nx_c;
            ny_q      <= ny_c;
            axis_q    <= 1'b0;
            lo_q      <= '0;
            hi_q      <= IW'(nx_c - 1'b1);
            outside_q <= 1'b0;
            zero_q    <= 1'b0;
            state_q   <= S_SRCH;
          end
        end
        S_SRCH: begin
          // Bisect while the bracket spans more than one cell.
          mid_q <= mid;
          if ((hi_q - lo_q) > IW'(1)) begin
            state_q <= S_CMP;
          end else begin
            state_q <= S_E0;
          end
        end
        S_CMP: begin
          if (bp_rd <= q_cur) begin
            lo_q <= mid_q;
          end else begin
            hi_q <= mid_q;
          end
          state_q <= S_SRCH;
        end
        S_E0: state_q <= S_E1;
        S_E1: begin
          if (q_cur < bp_rd) outside_q <= 1'b1;
          state_q <= S_E2;
        end
        S_E2: begin
          if (q_cur > bp_rd) outside_q <= 1'b1;
          state_q <= S_E3;
        end
        S_E3: begin
          if (axis_q) y1_q <= bp_rd;
          else        x1_q <= bp_rd;
          state_q <= S_E4;
        end
        S_E4: begin
          if (axis_q) begin
            y2_q    <= bp_rd;
            base_q  <= TW'(i_q) * TW'(ny_q);
            state_q <= S_ZCHK;
          end else begin
            x2_q    <= bp_rd;
            i_q     <= lo_q;
            axis_q  <= 1'b1;
            lo_q    <= '0;
            hi_q    <= IW'(ny_q - 1'b1);
            state_q <= S_SRCH;
          end
        end
        S_ZCHK: begin
          if ((dx == '0) || (dy == '0)) begin
            zero_q  <= 1'b1;
            fin_q   <= 1'b1;
            state_q <= S_DIV;
          end else begin
            // The first corner's value read is issued in the next cycle.
            c_q     <= '0;
            state_q <= S_DEN;
          end
        end
        S_DEN: begin
          den_q   <= mul_q;
          dneg_q  <= dx[32] ^ dy[32];
          acc_q   <= '0;
          c_q     <= '0;
          state_q <= S_CW;
        end
        S_CW: begin
          vmag_q  <= mag32(v_rd_q);
          tneg_q  <= wx[32] ^ wy[32] ^ v_rd_q[31];
          state_q <= S_CL;
        end
        S_CL: begin
          p1_q    <= mul_q;
          state_q <= S_CH;
        end
        S_CH: begin
          acc_q   <= tneg_q ? acc_q - $signed(term) : acc_q + $signed(term);
          state_q <= S_CA;
        end
        S_CA: begin
          acc_q <= tneg_q ? acc_q - $signed(term) : acc_q + $signed(term);
          c_q   <= c_q + 1'b1;
          if (c_q == 2'd3) begin
            state_q <= S_DST;
          end else begin
            state_q <= S_CW;
          end
        end
        S_DST: begin
          numneg_q <= acc_q[AW-1];
          state_q  <= S_DIV;
        end
        S_DIV: begin
          if (res_ready) begin
            if (out_free) begin
              interp_q    <= res_value;
              status_q    <= res_status;
              fin_q       <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              fin_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = interp_q;
  assign status_o       = status_q;

  // The bisection bracket stays ordered while searching.
  `BINT_ASSERT(a_srch_order, clk_i, rst_ni, (state_q == S_SRCH) |-> (lo_q < hi_q), "search bracket out of order")
  // The divider only finishes while the sequencer waits on it.
  `BINT_ASSERT(a_div_owner, clk_i, rst_ni, div_done |-> (state_q == S_DIV), "divider done outside divide state")
  // A new result only appears out of the divide state.
  `BINT_ASSERT(a_out_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DIV), "result loaded from wrong state")
  // A saturated result carries one of the two limits.
  `BINT_ASSERT(a_sat_val, clk_i, rst_ni, (out_valid_q && (status_q == bint_pkg::ST_SAT)) |-> ((interp_q == 32'sh7FFF_FFFF) || (interp_q == 32'sh8000_0000)), "saturated value not a limit")
  // A zero-area cell always reports zero.
  `BINT_ASSERT_NEVER(a_zero_val, clk_i, rst_ni, out_valid_q && (status_q == bint_pkg::ST_ZERO) && (interp_q != '0), "zero-area result not zero")

endmodule
